### hdl/lso_pkg.sv
// ----------------------------------------------------------------------------
// lso_pkg
// Shared types, constants and helpers of the lidar sector obstacle avoider.
// ----------------------------------------------------------------------------
package lso_pkg;

  localparam int unsigned PosW        = 10;
  localparam int unsigned RangeW      = 16;
  localparam int unsigned SpeedW      = 16;
  localparam int unsigned CountW      = 8;
  localparam int unsigned TurnW       = 15;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned ProdW       = 33;
  localparam int unsigned WideW       = 28;
  localparam int unsigned OutTdataW   = 40;

  localparam int unsigned DefRightStart  = 0;
  localparam int unsigned DefFrontStart  = 310;
  localparam int unsigned DefLeftStart   = 620;
  localparam int unsigned DefSectorWidth = 100;
  localparam int unsigned DefScanSamples = 721;

  localparam logic [RangeW-1:0]  RangeInit = 16'd10240;   // 40.0 m
  localparam logic [PosW-1:0]    PosMax    = '1;
  localparam logic signed [WideW-1:0] OneQ88 = 28'sd256;
  localparam logic signed [ProdW:0]   RoundHalf = 34'sd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_COEFF    = 3'd0,
    CFG_CLEAR_DISTANCE = 3'd1,
    CFG_ANGULAR_GAIN   = 3'd2,
    CFG_LINEAR_GAIN    = 3'd3,
    CFG_TURN_SPEED     = 3'd4,
    CFG_EXIT_HOLD      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_coeff;
    logic [RangeW-1:0]        clear_distance;
    logic [RangeW-1:0]        angular_gain;
    logic [RangeW-1:0]        linear_gain;
    logic [TurnW-1:0]         turn_speed;
    logic [CountW-1:0]        exit_hold;
  } cfg_t;

  // sector minima of one finished scan
  typedef struct packed {
    logic [RangeW-1:0] front_min;
    logic [RangeW-1:0] right_min;
    logic [RangeW-1:0] left_min;
  } scan_sum_t;

  function automatic logic signed [SpeedW-1:0] sat16(input logic signed [WideW-1:0] v);
    logic signed [SpeedW-1:0] r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/lidar_sector_obstacle_avoider.sv
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_avoider
// Folds lidar range samples into sector minima and issues one drive command
// at the end of each scan.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[15:0] range_sample, tlast last_of_scan
//   m_axis    out  tvalid/tready          tdata linear, angular, obstacle_ahead
//   cfg       in   cfg_we_i (no wait)     cfg_idx_i register, cfg_data_i value
//
// one sample accepted per cycle unless a pending request is held by a stall; the
// sector minima update in the cycle of acceptance, so that compare loop sets the rate.
// a command reaches m_axis after its last sample by way of the request register,
// the product register (16x17 multiply) and the output register.
// reset clears the position counter, exit countdown and valid bits and sets the
// minima to RangeInit; configuration returns to its defaults.
// output stalls back up through the pipeline registers to s_axis_tready.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_avoider import lso_pkg::*; #(
  parameter int unsigned RIGHT_START  = DefRightStart,
  parameter int unsigned FRONT_START  = DefFrontStart,
  parameter int unsigned LEFT_START   = DefLeftStart,
  parameter int unsigned SECTOR_WIDTH = DefSectorWidth,
  parameter int unsigned SCAN_SAMPLES = DefScanSamples
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RangeW-1:0]    s_axis_tdata,   // [15:0] range_sample
  input  logic                 s_axis_tlast,   // last_of_scan
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] linear_speed, [31:16] angular_speed, [32] obstacle_ahead, [39:33] zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t                     cfg;
  logic                     req_valid, req_ready;
  scan_sum_t                req;
  logic signed [SpeedW-1:0] linear_speed, angular_speed;
  logic                     obstacle_ahead;

  lso_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lso_sector_track #(
    .RIGHT_START  (RIGHT_START),
    .FRONT_START  (FRONT_START),
    .LEFT_START   (LEFT_START),
    .SECTOR_WIDTH (SECTOR_WIDTH),
    .SCAN_SAMPLES (SCAN_SAMPLES)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .range_sample_i (s_axis_tdata),
    .last_of_scan_i (s_axis_tlast),
    .req_valid_o    (req_valid),
    .req_ready_i    (req_ready),
    .req_o          (req)
  );

  lso_cmd_unit u_cmd (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .req_valid_i      (req_valid),
    .req_ready_o      (req_ready),
    .req_i            (req),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .linear_speed_o   (linear_speed),
    .angular_speed_o  (angular_speed),
    .obstacle_ahead_o (obstacle_ahead)
  );

  assign m_axis_tdata = {7'b0, obstacle_ahead, angular_speed, linear_speed};

endmodule

### hdl/lso_cfg_regs.sv
// ----------------------------------------------------------------------------
// lso_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lso_cfg_regs import lso_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED_COEFF:    cfg_d.speed_coeff    = $signed(cfg_data_i);
        CFG_CLEAR_DISTANCE: cfg_d.clear_distance = cfg_data_i;
        CFG_ANGULAR_GAIN:   cfg_d.angular_gain   = cfg_data_i;
        CFG_LINEAR_GAIN:    cfg_d.linear_gain    = cfg_data_i;
        CFG_TURN_SPEED:     cfg_d.turn_speed     = cfg_data_i[TurnW-1:0];
        CFG_EXIT_HOLD:      cfg_d.exit_hold      = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_coeff    <= '0;
      cfg_q.clear_distance <= 16'd384;
      cfg_q.angular_gain   <= 16'd64;
      cfg_q.linear_gain    <= 16'd128;
      cfg_q.turn_speed     <= 15'd51;
      cfg_q.exit_hold      <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/lso_sector_track.sv
// ----------------------------------------------------------------------------
// lso_sector_track
// Counts samples within a scan and keeps the right, front and left minima.
// On the last sample it hands the minima on as one request.
// ----------------------------------------------------------------------------
module lso_sector_track import lso_pkg::*; #(
  parameter int unsigned RIGHT_START  = DefRightStart,
  parameter int unsigned FRONT_START  = DefFrontStart,
  parameter int unsigned LEFT_START   = DefLeftStart,
  parameter int unsigned SECTOR_WIDTH = DefSectorWidth,
  parameter int unsigned SCAN_SAMPLES = DefScanSamples
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RangeW-1:0] range_sample_i,
  input  logic              last_of_scan_i,
  output logic              req_valid_o,
  input  logic              req_ready_i,
  output scan_sum_t         req_o
);

  localparam int unsigned CmpW = PosW + 1;
  localparam logic [CmpW-1:0] RightLo = CmpW'(RIGHT_START);
  localparam logic [CmpW-1:0] RightHi = CmpW'(RIGHT_START + SECTOR_WIDTH);
  localparam logic [CmpW-1:0] FrontLo = CmpW'(FRONT_START);
  localparam logic [CmpW-1:0] FrontHi = CmpW'(FRONT_START + SECTOR_WIDTH);
  localparam logic [CmpW-1:0] LeftLo  = CmpW'(LEFT_START);
  localparam logic [CmpW-1:0] LeftHi  = CmpW'(LEFT_START + SECTOR_WIDTH);
  localparam logic [CmpW-1:0] ScanLen = CmpW'(SCAN_SAMPLES);

  logic [PosW-1:0]   pos_q, pos_d;
  scan_sum_t         mins_q, mins_d, mins_new;
  scan_sum_t         req_q, req_d;
  logic              req_valid_q, req_valid_d;
  logic              accept;
  logic [CmpW-1:0]   pos_x;
  logic              in_scan, in_right, in_front, in_left;

  assign in_ready_o = !req_valid_q || req_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_x    = {1'b0, pos_q};
  assign in_scan  = pos_x < ScanLen;
  assign in_right = in_scan && pos_x >= RightLo && pos_x < RightHi;
  assign in_front = in_scan && pos_x >= FrontLo && pos_x < FrontHi;
  assign in_left  = in_scan && pos_x >= LeftLo  && pos_x < LeftHi;

  always_comb begin
    mins_new = mins_q;
    if (in_right && range_sample_i <= mins_q.right_min) mins_new.right_min = range_sample_i;
    if (in_front && range_sample_i <= mins_q.front_min) mins_new.front_min = range_sample_i;
    if (in_left  && range_sample_i <= mins_q.left_min)  mins_new.left_min  = range_sample_i;
  end

  always_comb begin
    pos_d       = pos_q;
    mins_d      = mins_q;
    req_d       = req_q;
    req_valid_d = req_valid_q && !req_ready_i;
    if (accept) begin
      if (last_of_scan_i) begin
        pos_d       = '0;
        mins_d      = '{front_min: RangeInit, right_min: RangeInit, left_min: RangeInit};
        req_d       = mins_new;
        req_valid_d = 1'b1;
      end else begin
        mins_d = mins_new;
        if (pos_q != PosMax) pos_d = pos_q + 1'b1;   // saturating position
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mins_q      <= '{front_min: RangeInit, right_min: RangeInit, left_min: RangeInit};
      req_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      mins_q      <= mins_d;
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_of_scan_i |=> pos_q == '0 && mins_q.front_min == RangeInit)
    else $error("scan not restarted after last sample");

  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !req_ready_i |=> req_valid_q && $stable(req_q))
    else $error("stalled request changed");

  a_min_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mins_q.front_min <= RangeInit && mins_q.right_min <= RangeInit
    && mins_q.left_min <= RangeInit)
    else $error("sector minimum above initial range");

endmodule

### hdl/lso_cmd_unit.sv
// ----------------------------------------------------------------------------
// lso_cmd_unit
// Turns the minima of one scan into a drive command: a product stage
// (decision, gain select, multiply, exit countdown) and a result stage
// (round, add, sign, saturate) feeding the output register.
// ----------------------------------------------------------------------------
module lso_cmd_unit import lso_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  scan_sum_t                req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SpeedW-1:0] linear_speed_o,
  output logic signed [SpeedW-1:0] angular_speed_o,
  output logic                     obstacle_ahead_o
);

  // product stage
  logic                    p_valid_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    blocked_q, blocked_d;
  logic                    scaled_q, scaled_d;
  logic                    turn_left_q, turn_left_d;
  logic [CountW-1:0]       cd_q, cd_d;
  logic                    p_en, r_en;
  logic [RangeW-1:0]       gain;
  logic signed [RangeW:0]  gain_s;

  // result stage
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] lin_q, lin_d;
  logic signed [SpeedW-1:0] ang_q, ang_d;
  logic                     obst_q;
  logic signed [ProdW:0]    rounded;
  logic signed [WideW-1:0]  mag, lin_w, ang_w;

  assign r_en        = !out_valid_q || out_ready_i;
  assign p_en        = !p_valid_q || r_en;
  assign req_ready_o = p_en;

  always_comb begin
    blocked_d   = !(req_i.front_min > cfg_i.clear_distance);
    turn_left_d = req_i.right_min < req_i.left_min;
    scaled_d    = blocked_d || (cd_q != '0);
    gain        = blocked_d ? cfg_i.angular_gain : cfg_i.linear_gain;
    gain_s      = $signed({1'b0, gain});
    prod_d      = cfg_i.speed_coeff * gain_s;
    cd_d        = cd_q;
    if (p_en && req_valid_i) begin
      if (blocked_d) begin
        cd_d = cfg_i.exit_hold;
      end else if (cd_q != '0) begin
        cd_d = cd_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      cd_q      <= '0;
    end else begin
      cd_q <= cd_d;
      if (p_en) p_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en) begin
      prod_q      <= prod_d;
      blocked_q   <= blocked_d;
      scaled_q    <= scaled_d;
      turn_left_q <= turn_left_d;
    end
  end

  // round half up, then add 1.0
  always_comb begin
    rounded = ($signed({prod_q[ProdW-1], prod_q}) + RoundHalf) >>> 8;
    mag     = OneQ88 + WideW'(rounded);
    if (blocked_q) begin
      lin_w = WideW'({1'b0, cfg_i.turn_speed});
      ang_w = turn_left_q ? mag : -mag;
    end else begin
      lin_w = scaled_q ? mag : OneQ88 + WideW'(cfg_i.speed_coeff);
      ang_w = '0;
    end
    lin_d = sat16(lin_w);
    ang_d = sat16(ang_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_en) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_en) begin
      lin_q  <= lin_d;
      ang_q  <= ang_d;
      obst_q <= blocked_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign linear_speed_o   = lin_q;
  assign angular_speed_o  = ang_q;
  assign obstacle_ahead_o = obst_q;

  a_clear_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !obst_q |-> ang_q == '0)
    else $error("turn command while front is clear");

  a_blocked_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_en && req_valid_i && blocked_d |=> cd_q == $past(cfg_i.exit_hold))
    else $error("exit countdown not reloaded on blocked scan");

  a_turn_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_en && p_valid_q && blocked_q |=> out_valid_q
    && lin_q == $signed({1'b0, $past(cfg_i.turn_speed)}))
    else $error("blocked command lost turn speed");

endmodule
